[rtl/tun_pkg.sv]
// Package for the triangle unit normal block: field widths and the control struct.
// No dependencies; used by tun_cross and triangle_unit_normal.
`timescale 1ns / 1ps
`default_nettype none
package tun_pkg;

  localparam int COORD_BITS = 16;
  localparam int EDGE_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * EDGE_W;
  localparam int CROSS_W    = PROD_W + 1;
  localparam int MAG_W      = CROSS_W - 1;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int NORM_FRAC  = 14;
  localparam int RES_W      = NORM_FRAC + 1;
  localparam int NSTEP      = RES_W;
  localparam int ACC_W      = SUM_W + 2 * NORM_FRAC + 6;
  localparam int OUT_W      = 16;

  typedef struct packed {
    logic       valid;
    logic       zero;
    logic [2:0] neg;
  } cross_ctrl_t;

endpackage
`default_nettype wire

[rtl/tun_cross.sv]
// Edge vectors and cross product of one triangle, three register stages.
// Depends on tun_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tun_cross
  import tun_pkg::*;
(
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  input  wire logic signed [COORD_BITS-1:0] coord_i [9],
  output cross_ctrl_t                       ctrl_o,
  output logic [MAG_W-1:0]                  mag_o [3]
);

  logic                     v1_q, v2_q;
  logic signed [EDGE_W-1:0] e0_q [3];
  logic signed [EDGE_W-1:0] e1_q [3];
  logic signed [PROD_W-1:0] p_q  [6];
  logic signed [CROSS_W-1:0] n_d [3];
  cross_ctrl_t              ctrl_q;
  logic [MAG_W-1:0]         mag_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      ctrl_q <= '0;
    end else begin
      v1_q         <= valid_i;
      v2_q         <= v1_q;
      ctrl_q.valid <= v2_q;
      ctrl_q.zero  <= (n_d[0] == '0) && (n_d[1] == '0) && (n_d[2] == '0);
      for (int i = 0; i < 3; i++) ctrl_q.neg[i] <= n_d[i][CROSS_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      e0_q[i] <= EDGE_W'(coord_i[3+i]) - EDGE_W'(coord_i[i]);
      e1_q[i] <= EDGE_W'(coord_i[6+i]) - EDGE_W'(coord_i[i]);
    end
    p_q[0] <= e0_q[1] * e1_q[2];
    p_q[1] <= e0_q[2] * e1_q[1];
    p_q[2] <= e0_q[2] * e1_q[0];
    p_q[3] <= e0_q[0] * e1_q[2];
    p_q[4] <= e0_q[0] * e1_q[1];
    p_q[5] <= e0_q[1] * e1_q[0];
    for (int i = 0; i < 3; i++) begin
      mag_q[i] <= n_d[i][CROSS_W-1] ? MAG_W'(-n_d[i]) : MAG_W'(n_d[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_d[i] = CROSS_W'(p_q[2*i]) - CROSS_W'(p_q[2*i+1]);
    end
  end

  assign ctrl_o = ctrl_q;
  assign mag_o  = mag_q;

endmodule
`default_nettype wire

[rtl/triangle_unit_normal.sv]
// Top level of the triangle unit normal block: squares, length sum and rounding pipeline.
// Depends on tun_pkg and tun_cross.
`timescale 1ns / 1ps
`default_nettype none
// A new triangle is taken in every clock cycle: busy_o never rises, so start_i may be held
// high for a continuous stream. Each triangle gives exactly one result word, shown for one
// cycle with valid_o high; the receiver cannot stall and must take it then. The pipeline has
// three stages for edges and the cross product, one for the squares, one for the squared
// length, fifteen for the bit-by-bit rounded division by the length (one result bit each),
// and one output register. Each normal component is the exactly rounded value of N_i / |N|
// in Q1.14, ties away from zero. A triangle whose cross product is exactly zero yields a
// zero vector with degenerate_o set.
module triangle_unit_normal
  import tun_pkg::*;
(
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic signed [COORD_BITS-1:0] a_x_i,
  input  wire logic signed [COORD_BITS-1:0] a_y_i,
  input  wire logic signed [COORD_BITS-1:0] a_z_i,
  input  wire logic signed [COORD_BITS-1:0] b_x_i,
  input  wire logic signed [COORD_BITS-1:0] b_y_i,
  input  wire logic signed [COORD_BITS-1:0] b_z_i,
  input  wire logic signed [COORD_BITS-1:0] c_x_i,
  input  wire logic signed [COORD_BITS-1:0] c_y_i,
  input  wire logic signed [COORD_BITS-1:0] c_z_i,
  output logic                              valid_o,
  output logic signed [OUT_W-1:0]           norm_x_o,
  output logic signed [OUT_W-1:0]           norm_y_o,
  output logic signed [OUT_W-1:0]           norm_z_o,
  output logic                              degenerate_o
);

  logic signed [COORD_BITS-1:0] coord [9];
  cross_ctrl_t                  cr_ctrl;
  logic [MAG_W-1:0]             cr_mag [3];

  assign busy_o = 1'b0;
  assign coord = '{a_x_i, a_y_i, a_z_i, b_x_i, b_y_i, b_z_i, c_x_i, c_y_i, c_z_i};

  tun_cross u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .coord_i (coord),
    .ctrl_o  (cr_ctrl),
    .mag_o   (cr_mag)
  );

  // Squares of the magnitudes.
  cross_ctrl_t     sq_ctrl_q;
  logic [SQ_W-1:0] sq_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_ctrl_q <= '0;
    end else begin
      sq_ctrl_q <= cr_ctrl;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) sq_q[i] <= cr_mag[i] * cr_mag[i];
  end

  // Rounding stages. For result r the test is s * (2r - 1)^2 <= m^2 * 2^(2F+2). The
  // residual d holds m^2 * 2^(2F+2) - s * (2r - 1)^2 and t holds s * (2r - 1), so adding
  // one result bit needs only shifts, two subtractions and one addition.
  cross_ctrl_t              st_ctrl_q [NSTEP+1];
  logic [SUM_W-1:0]         st_s_q    [NSTEP+1];
  logic signed [ACC_W-1:0]  st_d_q    [NSTEP+1][3];
  logic signed [ACC_W-1:0]  st_t_q    [NSTEP+1][3];
  logic [RES_W-1:0]         st_r_q    [NSTEP+1][3];

  logic [SUM_W-1:0] sum_d;
  assign sum_d = SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_ctrl_q[0] <= '0;
    end else begin
      st_ctrl_q[0] <= sq_ctrl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    st_s_q[0] <= sum_d;
    for (int i = 0; i < 3; i++) begin
      st_d_q[0][i] <= (ACC_W'(sq_q[i]) <<< (2 * NORM_FRAC + 2)) - ACC_W'(sum_d);
      st_t_q[0][i] <= -ACC_W'(sum_d);
      st_r_q[0][i] <= '0;
    end
  end

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    localparam int Bit = NSTEP - 1 - k;
    logic signed [ACC_W-1:0] tst [3];
    logic [2:0]              take;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        tst[i]  = st_d_q[k][i] - (st_t_q[k][i] <<< (Bit + 2))
                  - (ACC_W'(st_s_q[k]) <<< (2 * Bit + 2));
        take[i] = !tst[i][ACC_W-1];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_ctrl_q[k+1] <= '0;
      end else begin
        st_ctrl_q[k+1] <= st_ctrl_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      st_s_q[k+1] <= st_s_q[k];
      for (int i = 0; i < 3; i++) begin
        st_d_q[k+1][i] <= take[i] ? tst[i] : st_d_q[k][i];
        st_t_q[k+1][i] <= take[i] ? st_t_q[k][i] + (ACC_W'(st_s_q[k]) <<< (Bit + 1))
                                  : st_t_q[k][i];
        st_r_q[k+1][i] <= st_r_q[k][i] | (RES_W'(take[i]) << Bit);
      end
    end
  end

  // Output register: apply the signs, force zero for a degenerate triangle.
  logic                    out_v_q, out_deg_q;
  logic signed [OUT_W-1:0] out_n_q [3];
  logic signed [OUT_W-1:0] mag_ext [3];

  always_comb begin
    for (int i = 0; i < 3; i++) mag_ext[i] = OUT_W'(st_r_q[NSTEP][i]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= st_ctrl_q[NSTEP].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_deg_q <= st_ctrl_q[NSTEP].zero;
    for (int i = 0; i < 3; i++) begin
      if (st_ctrl_q[NSTEP].zero) begin
        out_n_q[i] <= '0;
      end else if (st_ctrl_q[NSTEP].neg[i]) begin
        out_n_q[i] <= -mag_ext[i];
      end else begin
        out_n_q[i] <= mag_ext[i];
      end
    end
  end

  assign valid_o      = out_v_q;
  assign norm_x_o     = out_n_q[0];
  assign norm_y_o     = out_n_q[1];
  assign norm_z_o     = out_n_q[2];
  assign degenerate_o = out_deg_q;

endmodule
`default_nettype wire

[bench/tb_triangle_unit_normal.sv]
// Testbench for triangle_unit_normal: random and directed triangles against an internal
// predictor of the rounded unit face normal. Depends on tun_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb_triangle_unit_normal;
  import tun_pkg::*;

  // One triangle as it goes onto the input ports. The hold flag makes the driver wait
  // until every outstanding normal has come back before this word is sent.
  typedef struct {
    logic signed [COORD_BITS-1:0] c [9];
    bit                           hold;
  } tri_word_t;

  // One expected result word.
  typedef struct packed {
    logic signed [OUT_W-1:0] nx, ny, nz;
    logic                    deg;
  } normal_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic signed [COORD_BITS-1:0] a_x_i = '0, a_y_i = '0, a_z_i = '0;
  logic signed [COORD_BITS-1:0] b_x_i = '0, b_y_i = '0, b_z_i = '0;
  logic signed [COORD_BITS-1:0] c_x_i = '0, c_y_i = '0, c_z_i = '0;
  logic busy_o, valid_o, degenerate_o;
  logic signed [OUT_W-1:0] norm_x_o, norm_y_o, norm_z_o;

  tri_word_t triangles_q[$];
  normal_t   normals_q[$];
  int        mismatches = 0;
  bit        failed = 1'b0;
  bit        took = 1'b0;
  int        burst_left = 0;
  int        gap_left = 0;

  triangle_unit_normal dut (.*);

  always #10 clk_i = ~clk_i;

  // Largest r in [0, 2^14] with s * (2r - 1)^2 <= m^2 * 2^30, which is the magnitude
  // m * 2^14 / sqrt(s) rounded to nearest with ties away from zero.
  function automatic logic [14:0] round_component(logic [63:0] m, logic [127:0] s);
    logic [127:0] rhs, t;
    logic [15:0]  lo, hi, mid;
    rhs = ({64'd0, m} * {64'd0, m}) << 30;
    lo = 0;
    hi = 16'd1 << NORM_FRAC;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      t = 2 * mid - 1;
      if (s * t * t <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo[14:0];
  endfunction

  function automatic normal_t face_normal(tri_word_t w);
    longint       e0 [3], e1 [3], n [3];
    logic [63:0]  m [3];
    logic [127:0] s;
    logic [15:0]  r;
    normal_t      res;
    for (int i = 0; i < 3; i++) begin
      e0[i] = longint'(w.c[3+i]) - longint'(w.c[i]);
      e1[i] = longint'(w.c[6+i]) - longint'(w.c[i]);
    end
    n[0] = e0[1] * e1[2] - e0[2] * e1[1];
    n[1] = e0[2] * e1[0] - e0[0] * e1[2];
    n[2] = e0[0] * e1[1] - e0[1] * e1[0];
    res = '{nx: '0, ny: '0, nz: '0, deg: 1'b1};
    if (n[0] == 0 && n[1] == 0 && n[2] == 0) return res;
    s = '0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (n[i] < 0) ? 64'(-n[i]) : 64'(n[i]);
      s += {64'd0, m[i]} * {64'd0, m[i]};
    end
    res.deg = 1'b0;
    for (int i = 0; i < 3; i++) begin
      r = {1'b0, round_component(m[i], s)};
      if (n[i] < 0) r = -r;
      if (i == 0) res.nx = r;
      else if (i == 1) res.ny = r;
      else res.nz = r;
    end
    return res;
  endfunction

  // Driver: new words go out at the falling edge. A word stays on the ports until the
  // rising edge has taken it; the sender runs in bursts separated by random gaps.
  always @(negedge clk_i) begin
    if (rst_ni && !(start_i && !took)) begin
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      if (gap_left > 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (triangles_q.size() > 0 &&
                   !(triangles_q[0].hold && normals_q.size() > 0)) begin
        tri_word_t w;
        w = triangles_q.pop_front();
        burst_left--;
        {a_x_i, a_y_i, a_z_i} <= {w.c[0], w.c[1], w.c[2]};
        {b_x_i, b_y_i, b_z_i} <= {w.c[3], w.c[4], w.c[5]};
        {c_x_i, c_y_i, c_z_i} <= {w.c[6], w.c[7], w.c[8]};
        start_i <= 1'b1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: at each rising edge, predict the normal of an accepted triangle and check
  // any result word that the block shows.
  always @(posedge clk_i) begin
    tri_word_t w;
    normal_t   got, want;
    took = start_i && !busy_o && rst_ni;
    if (took) begin
      w.c = '{a_x_i, a_y_i, a_z_i, b_x_i, b_y_i, b_z_i, c_x_i, c_y_i, c_z_i};
      w.hold = 1'b0;
      normals_q.push_back(face_normal(w));
    end
    if (rst_ni && valid_o) begin
      got = '{nx: norm_x_o, ny: norm_y_o, nz: norm_z_o, deg: degenerate_o};
      if (normals_q.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", got);
      end else begin
        want = normals_q.pop_front();
        if (got !== want) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10) $display("normal mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  function automatic logic signed [COORD_BITS-1:0] rand_coord(int spread);
    if (spread == 0) return $urandom();
    return $urandom_range(0, 2 * spread) - spread;
  endfunction

  task automatic add_tri(input int v [9], input bit hold = 1'b0);
    tri_word_t w;
    foreach (v[i]) w.c[i] = v[i];
    w.hold = hold;
    triangles_q.push_back(w);
  endtask

  initial begin
    int v [9];
    int k;
    // Directed part: all corners equal, extremes of the coordinates, axis-aligned
    // faces, collinear corners and a few mixed-sign cases.
    add_tri('{0, 0, 0, 0, 0, 0, 0, 0, 0});
    add_tri('{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768});
    add_tri('{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767});
    add_tri('{0, 0, 0, 256, 0, 0, 0, 256, 0});
    add_tri('{0, 0, 0, 0, 256, 0, 256, 0, 0});
    add_tri('{0, 0, 0, 0, 256, 0, 0, 0, 256});
    add_tri('{0, 0, 0, 0, 0, 256, 256, 0, 0});
    add_tri('{-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768});
    add_tri('{32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767});
    add_tri('{-32768, -32768, -32768, 32767, 32767, 32767, -32768, 32767, 32767});
    add_tri('{32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767, -32768});
    add_tri('{0, 0, 0, 1, 1, 1, 2, 2, 2});
    add_tri('{-32768, 0, 32767, 32767, 0, -32768, 0, 0, 0});
    add_tri('{0, 0, 0, 1, 0, 0, 0, 1, 0});
    add_tri('{0, 0, 0, 1, 0, 0, 0, 0, 1});
    add_tri('{0, 0, 0, 1, 1, 0, 1, 0, 1});
    add_tri('{100, -200, 300, 100, -200, 300, 5, 6, 7});
    add_tri('{-1, -1, -1, 0, -1, -1, -1, 0, -1});
    add_tri('{32767, 0, 0, 0, 32767, 0, 0, 0, 32767});
    add_tri('{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768});
    // Random part: mostly full-range corners, some tight triangles, some degenerate.
    for (int n = 0; n < 600; n++) begin
      k = $urandom_range(0, 9);
      foreach (v[i]) v[i] = rand_coord(k < 6 ? 0 : (k < 8 ? 64 : 4));
      if (k == 9) begin
        // Collinear or coincident corners: C = A + t * (B - A).
        int t;
        t = $urandom_range(0, 4) - 2;
        for (int i = 0; i < 3; i++) v[6+i] = v[i] + t * (v[3+i] - v[i]);
      end
      add_tri(v, n == 300);
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    wait (triangles_q.size() == 0);
    @(negedge clk_i);
    wait (!start_i);
    wait (normals_q.size() == 0);
    repeat (30) @(posedge clk_i);
    if (!failed && normals_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
